>>> sv/grc_pkg.sv
// Package for the Givens rotation cascade core: constants, command codes and types.
// No dependencies; every other file imports it.
package grc_pkg;
    localparam int MaxLog2Size = 10;
    localparam int SampleWidth = 24;
    localparam int RotEntries = 21;
    localparam int StoreDepth = 1 << MaxLog2Size;
    localparam int AddrW = MaxLog2Size;
    localparam int RotAddrW = $clog2(RotEntries);

    typedef logic signed [SampleWidth-1:0] t_sample;
    typedef logic signed [15:0] t_coef;

    localparam logic [2:0] CmdWrSample = 3'd0;
    localparam logic [2:0] CmdWrRot = 3'd1;
    localparam logic [2:0] CmdFwd = 3'd2;
    localparam logic [2:0] CmdInv = 3'd3;
    localparam logic [2:0] CmdRdSample = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PLAN,
        ST_RD_A,
        ST_RD_B,
        ST_MUL,
        ST_SUM,
        ST_WR_A,
        ST_WR_B
    } t_state;

    // Rounded Q1.15 product: (x*c + 2^14) >> 15.
    function automatic logic signed [SampleWidth+1:0] rnd_mul(t_sample x, t_coef c);
        logic signed [SampleWidth+16:0] p;
        p = (SampleWidth+17)'(x) * (SampleWidth+17)'(c) + (SampleWidth+17)'(16384);
        return p[SampleWidth+16:15];
    endfunction

    // Saturate a wide sum to the sample width.
    function automatic t_sample sat(logic signed [SampleWidth+2:0] v);
        logic signed [SampleWidth+2:0] hi;
        logic signed [SampleWidth+2:0] lo;
        hi = (SampleWidth+3)'((1 << (SampleWidth-1)) - 1);
        lo = -hi - (SampleWidth+3)'(1);
        if (v > hi) return hi[SampleWidth-1:0];
        if (v < lo) return lo[SampleWidth-1:0];
        return v[SampleWidth-1:0];
    endfunction
endpackage

>>> sv/givens_rotation_cascade_core.sv
// Top level of the Givens rotation cascade core: sample memory, rotation table, run sequencer.
// Depends on grc_pkg.
// Loads, reads and rejected commands: result in the cycle after the item, one item per cycle while no run holds busy.
// A run holds busy high through a planning state, then the read a, read b, multiply, sum,
// write a and write b states per rotation through the single-port sample memory. Its one
// result strobe comes in the first cycle with busy low, as busy falls.
// Reset is synchronous and active low; it clears control state and sets log2_size to 4.
// Sample memory and rotation table are undefined until written; the receiver cannot stall.
module givens_rotation_cascade_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_cfg_we,
    input  logic [3:0]             i_cfg_data,
    input  logic [2:0]             i_command,
    input  logic [9:0]             i_index,
    input  grc_pkg::t_sample       i_sample_value,
    input  grc_pkg::t_coef         i_sine_value,
    input  grc_pkg::t_coef         i_cosine_value,
    output logic                   o_valid,
    output grc_pkg::t_sample       o_read_value,
    output logic                   o_status
);
    import grc_pkg::*;

    t_sample mem [StoreDepth];
    logic [31:0] rot [RotEntries];

    t_state r_state, n_state;
    logic [3:0] r_log2;
    logic r_inv;
    logic [3:0] r_tiers, r_t;
    logic [AddrW:0] r_blocks, r_i, r_fin;
    logic [2:0] r_j;
    logic r_last;
    logic [AddrW-1:0] r_pa, r_pb;
    logic [RotAddrW+1:0] r_e;
    t_sample r_rd, r_x, r_y, wr_a, wr_b;
    t_coef r_s, r_c;
    logic signed [SampleWidth+1:0] r_xc, r_ys, r_xs, r_yc;
    logic r_valid, r_status;

    logic [AddrW:0] vec_size;
    assign vec_size = (AddrW+1)'(1) << r_log2;

    // Config write with clamping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2 <= 4'd4;
        end else if (i_cfg_we) begin
            if (i_cfg_data < 4'd4) r_log2 <= 4'd4;
            else if (i_cfg_data > 4'(MaxLog2Size)) r_log2 <= 4'(MaxLog2Size);
            else r_log2 <= i_cfg_data;
        end
    end

    logic acc;
    assign acc = start && !busy;
    assign busy = (r_state != ST_IDLE);

    // Address of the current rotation pair, from tier, block and step.
    logic [AddrW+3:0] stride, base;
    logic [AddrW-1:0] pa_c, pb_c;
    logic [RotAddrW+1:0] e_c;
    always_comb begin
        stride = (AddrW+4)'(2) << (3 * (r_last ? r_tiers : r_t));
        base = r_last ? (stride - (AddrW+4)'(1))
                      : ((AddrW+4)'(r_i) * (stride << 3) + stride - (AddrW+4)'(1));
        pa_c = AddrW'(base + (AddrW+4)'(r_j) * stride);
        pb_c = AddrW'(base + (AddrW+4)'(r_j + 4'd1) * stride);
        e_c = (RotAddrW+2)'(7 * (r_last ? r_tiers : r_t)) + (RotAddrW+2)'(r_j);
    end

    // Next state.
    logic step_done_tier;
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (acc && (i_command == CmdFwd || i_command == CmdInv)) n_state = ST_PLAN;
            ST_PLAN: n_state = ST_RD_A;
            ST_RD_A: n_state = ST_RD_B;
            ST_RD_B: n_state = ST_MUL;
            ST_MUL:  n_state = ST_SUM;
            ST_SUM:  n_state = ST_WR_A;
            ST_WR_A: n_state = ST_WR_B;
            ST_WR_B: n_state = step_done_tier ? ST_IDLE : ST_RD_A;
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer position: forward walks tiers up then the final tier; inverse the reverse.
    // The inverse final tier is always followed by the regular tiers, so it never ends a run.
    logic [AddrW:0] lc;
    logic [3:0] tc;
    always_comb begin
        step_done_tier = 1'b0;
        if (r_last) begin
            step_done_tier = !r_inv && ((4'(r_j) + 4'd1) >= 4'(r_fin));
        end else if (r_inv) begin
            step_done_tier = (r_j == 3'd0) && (r_i + 1'b1 >= r_blocks) && (r_t == 4'd0);
        end else begin
            step_done_tier = (r_j == 3'd6) && (r_i + 1'b1 >= r_blocks)
                             && (r_t + 4'd1 >= r_tiers) && (r_fin == '0);
        end
    end

    logic [AddrW:0] blocks_of_t;
    always_comb begin
        blocks_of_t = (vec_size >> 4) >> (3 * r_t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Tier count and final-tier length at run start.
    always_comb begin
        lc = vec_size >> 4;
        tc = 4'd1;
        for (int k = 0; k < 3; k++) begin
            if (lc > (AddrW+1)'(8)) begin
                lc = lc >> 3;
                tc = tc + 4'd1;
            end
        end
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && acc) begin
            r_inv <= (i_command == CmdInv);
        end
        if (r_state == ST_PLAN) begin
            r_tiers <= tc;
            r_fin <= (lc > 0) ? lc - 1'b1 : '0;
            if (!r_inv) begin
                r_last <= 1'b0;
                r_t <= 4'd0;
                r_i <= '0;
                r_j <= 3'd0;
                r_blocks <= vec_size >> 4;
            end else if (lc > (AddrW+1)'(1)) begin
                r_last <= 1'b1;
                r_j <= 3'((lc - 1'b1) - 1'b1);
                r_t <= tc;
                r_i <= '0;
                r_blocks <= '0;
            end else begin
                r_last <= 1'b0;
                r_t <= tc - 4'd1;
                r_i <= '0;
                r_j <= 3'd6;
                r_blocks <= (vec_size >> 4) >> (3 * (tc - 4'd1));
            end
        end
        if (r_state == ST_WR_B) begin
            if (!r_inv) begin
                if (r_last) begin
                    r_j <= r_j + 3'd1;
                end else if (r_j != 3'd6) begin
                    r_j <= r_j + 3'd1;
                end else if (r_i + 1'b1 < r_blocks) begin
                    r_j <= 3'd0;
                    r_i <= r_i + 1'b1;
                end else if (r_t + 4'd1 < r_tiers) begin
                    r_j <= 3'd0;
                    r_i <= '0;
                    r_t <= r_t + 4'd1;
                    r_blocks <= blocks_of_t >> 3;
                end else begin
                    r_j <= 3'd0;
                    r_last <= 1'b1;
                end
            end else begin
                if (r_last) begin
                    if (r_j != 3'd0) begin
                        r_j <= r_j - 3'd1;
                    end else begin
                        r_last <= 1'b0;
                        r_t <= r_tiers - 4'd1;
                        r_i <= '0;
                        r_j <= 3'd6;
                        r_blocks <= (vec_size >> 4) >> (3 * (r_tiers - 4'd1));
                    end
                end else if (r_j != 3'd0) begin
                    r_j <= r_j - 3'd1;
                end else if (r_i + 1'b1 < r_blocks) begin
                    r_j <= 3'd6;
                    r_i <= r_i + 1'b1;
                end else begin
                    r_j <= 3'd6;
                    r_i <= '0;
                    r_t <= r_t - 4'd1;
                    r_blocks <= blocks_of_t << 3;
                end
            end
        end
    end

    // Memory read address, coefficient fetch.
    logic [AddrW-1:0] rd_addr;
    always_comb begin
        rd_addr = (r_state == ST_RD_B) ? r_pb : (r_state == ST_RD_A) ? pa_c : i_index[AddrW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RD_A) begin
            r_pa <= pa_c;
            r_pb <= pb_c;
            r_e <= e_c;
        end
        r_rd <= mem[rd_addr];
        if (r_state == ST_RD_B) begin
            r_x <= r_rd;
            if (r_e < (RotAddrW+2)'(RotEntries)) begin
                r_s <= rot[RotAddrW'(r_e)][31:16];
                r_c <= rot[RotAddrW'(r_e)][15:0];
            end else begin
                r_s <= '0;
                r_c <= '0;
            end
        end
        if (r_state == ST_MUL) begin
            r_y <= r_rd;
            r_xc <= rnd_mul(r_x, r_c);
            r_xs <= rnd_mul(r_x, r_s);
        end
        if (r_state == ST_SUM) begin
            r_yc <= rnd_mul(r_y, r_c);
            r_ys <= rnd_mul(r_y, r_s);
        end
    end

    // Sums, saturation and write-back; also load writes.
    always_comb begin
        if (!r_inv) begin
            wr_a = sat((SampleWidth+3)'(r_xc) - (SampleWidth+3)'(r_ys));
            wr_b = sat((SampleWidth+3)'(r_xs) + (SampleWidth+3)'(r_yc));
        end else begin
            wr_a = sat((SampleWidth+3)'(r_xc) + (SampleWidth+3)'(r_ys));
            wr_b = sat((SampleWidth+3)'(r_yc) - (SampleWidth+3)'(r_xs));
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WR_A) begin
            mem[r_pa] <= wr_a;
        end else if (r_state == ST_WR_B) begin
            mem[r_pb] <= wr_b;
        end else if (acc && i_command == CmdWrSample && (AddrW+1)'(i_index) < vec_size) begin
            mem[i_index[AddrW-1:0]] <= i_sample_value;
        end
        if (acc && i_command == CmdWrRot && i_index < 10'(RotEntries)) begin
            rot[RotAddrW'(i_index)] <= {i_sine_value, i_cosine_value};
        end
    end

    // Result strobe.
    logic r_rd_pend;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            r_valid <= (acc && i_command != CmdFwd && i_command != CmdInv)
                       || (r_state == ST_WR_B && step_done_tier);
            r_rd_pend <= acc && i_command == CmdRdSample && (AddrW+1)'(i_index) < vec_size;
        end
        if (acc) begin
            case (i_command)
                CmdWrSample, CmdRdSample: r_status <= !((AddrW+1)'(i_index) < vec_size);
                CmdWrRot: r_status <= !(i_index < 10'(RotEntries));
                CmdFwd, CmdInv: r_status <= 1'b0;
                default: r_status <= 1'b1;
            endcase
        end else if (r_state == ST_WR_B) begin
            r_status <= 1'b0;
        end
    end

    assign o_valid = r_valid;
    assign o_status = r_status;
    assign o_read_value = r_rd_pend ? r_rd : '0;
endmodule

>>> sv/grc_checker.sv
// Port checker for the Givens rotation cascade core, with its bind.
// Depends on grc_pkg.
module grc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input logic o_status,
    input grc_pkg::t_sample o_read_value
);
    import grc_pkg::*;

    // A rejected item never returns data.
    a_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_read_value == '0) else $error("rejected item has data");

    // Idle accepted item answers in the next cycle.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy ##1 !busy |-> o_valid) else $error("missing result");

    // No result without an accepted item or a finished run.
    a_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy) || $fell(busy)) else $error("spurious result");
endmodule

bind givens_rotation_cascade_core grc_checker u_grc_checker (.*);

>>> sim/testbench.sv
// Self-checking testbench for givens_rotation_cascade_core: loads, reads and rotation runs.
// Depends on grc_pkg and the core; keeps its own model of the sample vector and rotation table.
module testbench;
    import grc_pkg::*;

    typedef struct {
        logic signed [SampleWidth-1:0] read_value;
        logic                          status;
    } t_reply;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic             i_cfg_we;
    logic [3:0]       i_cfg_data;
    logic [2:0]       i_command;
    logic [9:0]       i_index;
    t_sample          i_sample_value;
    t_coef            i_sine_value;
    t_coef            i_cosine_value;
    logic             o_valid;
    t_sample          o_read_value;
    logic             o_status;

    // Model state of the block.
    int               vec_mem[StoreDepth];
    bit               sample_written[StoreDepth];
    int               rot_sin[RotEntries];
    int               rot_cos[RotEntries];
    int unsigned      vec_log2;
    t_reply           pending_replies[$];
    int               error_count;
    bit               gaps_on;

    givens_rotation_cascade_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_command),
        .i_index        (i_index),
        .i_sample_value (i_sample_value),
        .i_sine_value   (i_sine_value),
        .i_cosine_value (i_cosine_value),
        .o_valid        (o_valid),
        .o_read_value   (o_read_value),
        .o_status       (o_status)
    );

    // Clock with a period of 10.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Rounded Q1.15 product, halves toward plus infinity.
    function automatic longint q15_product(longint x, longint c);
        return (x * c + 64'sd16384) >>> 15;
    endfunction

    // Saturate a sum to the sample width.
    function automatic int clip_sample(longint v);
        if (v > 64'sd8388607) return 8388607;
        if (v < -64'sd8388608) return -8388608;
        return int'(v);
    endfunction

    // Apply one plane rotation to two samples of the model vector.
    task automatic rotate_pair(int unsigned pa, int unsigned pb, int unsigned e, bit inv);
        longint s;
        longint c;
        longint x;
        longint y;
        s = 0;
        c = 0;
        pa = pa % StoreDepth;
        pb = pb % StoreDepth;
        if (e < RotEntries) begin
            s = rot_sin[e];
            c = rot_cos[e];
        end
        x = vec_mem[pa];
        y = vec_mem[pb];
        if (!inv) begin
            vec_mem[pa] = clip_sample(q15_product(x, c) - q15_product(y, s));
            vec_mem[pb] = clip_sample(q15_product(x, s) + q15_product(y, c));
        end else begin
            vec_mem[pa] = clip_sample(q15_product(x, c) + q15_product(y, s));
            vec_mem[pb] = clip_sample(q15_product(y, c) - q15_product(x, s));
        end
    endtask

    // Forward or inverse cascade over all tiers and the final partial tier.
    task automatic run_cascade(bit inv);
        int unsigned blocks[8];
        int unsigned tiers;
        int unsigned lc;
        int unsigned stride;
        int unsigned base;
        int unsigned fin;
        int          t;
        int          j;
        tiers = 0;
        lc = (1 << vec_log2) >> 4;
        while (1) begin
            blocks[tiers] = lc;
            tiers++;
            if (lc <= 8 || tiers >= 8) break;
            lc = lc / 8;
        end
        fin = (lc > 0) ? lc - 1 : 0;
        if (!inv) begin
            for (t = 0; t < tiers; t++) begin
                stride = 2 << (3 * t);
                for (int i = 0; i < blocks[t]; i++) begin
                    base = i * stride * 8 + stride - 1;
                    for (j = 0; j < 7; j++)
                        rotate_pair(base + j * stride, base + (j + 1) * stride, 7 * t + j, 1'b0);
                end
            end
            stride = 2 << (3 * tiers);
            for (j = 0; j < fin; j++)
                rotate_pair(stride - 1 + j * stride, stride - 1 + (j + 1) * stride,
                            7 * tiers + j, 1'b0);
        end else begin
            stride = 2 << (3 * tiers);
            for (j = int'(fin) - 1; j >= 0; j--)
                rotate_pair(stride - 1 + j * stride, stride - 1 + (j + 1) * stride,
                            7 * tiers + j, 1'b1);
            for (t = int'(tiers) - 1; t >= 0; t--) begin
                stride = 2 << (3 * t);
                for (int i = 0; i < blocks[t]; i++) begin
                    base = i * stride * 8 + stride - 1;
                    for (j = 6; j >= 0; j--)
                        rotate_pair(base + j * stride, base + (j + 1) * stride, 7 * t + j, 1'b1);
                end
            end
        end
    endtask

    // Work out the reply to one accepted item and update the model.
    task automatic predict_reply(logic [2:0] cmd, logic [9:0] idx, t_sample sv,
                                 t_coef s, t_coef c, output t_reply r);
        int unsigned n;
        n = 1 << vec_log2;
        r.read_value = '0;
        r.status = 1'b0;
        case (cmd)
            CmdWrSample: begin
                if (idx < n) begin
                    vec_mem[idx] = sv;
                    sample_written[idx] = 1'b1;
                end else begin
                    r.status = 1'b1;
                end
            end
            CmdWrRot: begin
                if (idx < RotEntries) begin
                    rot_sin[idx] = s;
                    rot_cos[idx] = c;
                end else begin
                    r.status = 1'b1;
                end
            end
            CmdFwd: run_cascade(1'b0);
            CmdInv: run_cascade(1'b1);
            CmdRdSample: begin
                if (idx < n) r.read_value = vec_mem[idx][SampleWidth-1:0];
                else r.status = 1'b1;
            end
            default: r.status = 1'b1;
        endcase
    endtask

    task automatic report_mismatch(string what);
        error_count++;
        $display("ERROR %s at %0t", what, $realtime);
    endtask

    // Compare each result strobe with the oldest pending reply.
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_valid) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("result with no item pending");
            end else begin
                want = pending_replies.pop_front();
                if (o_read_value !== want.read_value)
                    report_mismatch($sformatf("read_value %0d, wanted %0d",
                                              o_read_value, want.read_value));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0b, wanted %0b", o_status, want.status));
            end
        end
    end

    // Send one item, with random gaps before it, and record its reply once accepted.
    task automatic send_item(logic [2:0] cmd, logic [9:0] idx, t_sample sv,
                             t_coef s, t_coef c);
        t_reply r;
        while (gaps_on && $urandom_range(99) < 31) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_command <= cmd;
        i_index <= idx;
        i_sample_value <= sv;
        i_sine_value <= s;
        i_cosine_value <= c;
        do @(posedge i_clk); while (busy);
        predict_reply(cmd, idx, sv, s, c, r);
        pending_replies.push_back(r);
    endtask

    // Wait for all replies, then write the size register.
    task automatic set_size(logic [3:0] value);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (value < 4) vec_log2 = 4;
        else if (value > MaxLog2Size) vec_log2 = MaxLog2Size;
        else vec_log2 = value;
    endtask

    // Fill every odd sample and the whole table; runs only touch odd samples, and reads of
    // even samples are steered to written ones.
    task automatic test_fill_storage();
        set_size(4'd10);
        for (int i = 0; i < StoreDepth / 2; i++)
            send_item(CmdWrSample, 10'(2 * i + 1), t_sample'($urandom), '0, '0);
        for (int i = 0; i < RotEntries; i++)
            send_item(CmdWrRot, 10'(i), '0, t_coef'($urandom), t_coef'($urandom));
    endtask

    // Directed items: field extremes, every command, rejected indexes and clamped sizes.
    task automatic test_directed();
        set_size(4'd0);
        send_item(CmdWrSample, 10'd0, 24'sh7FFFFF, '0, '0);
        send_item(CmdWrSample, 10'd15, 24'sh800000, '0, '0);
        send_item(CmdWrSample, 10'd16, 24'sh123456, '0, '0);
        send_item(CmdWrRot, 10'd0, '0, 16'sh0000, 16'sh7FFF);
        send_item(CmdWrRot, 10'd1, '0, 16'sh8000, 16'sh8000);
        send_item(CmdWrRot, 10'd2, '0, 16'sh7FFF, 16'sh7FFF);
        send_item(CmdWrRot, 10'd21, '0, 16'sh1234, 16'sh4321);
        send_item(CmdWrRot, 10'd1023, '0, 16'sh7FFF, 16'sh8000);
        send_item(CmdFwd, 10'd1023, 24'sh7FFFFF, 16'sh7FFF, 16'sh7FFF);
        send_item(CmdRdSample, 10'd0, '0, '0, '0);
        send_item(CmdRdSample, 10'd15, '0, '0, '0);
        send_item(CmdRdSample, 10'd1023, '0, '0, '0);
        send_item(CmdInv, 10'd0, '0, '0, '0);
        send_item(CmdRdSample, 10'd1, '0, '0, '0);
        send_item(3'd5, 10'd0, '0, '0, '0);
        send_item(3'd6, 10'd3, '0, '0, '0);
        send_item(3'd7, 10'd1023, 24'sh7FFFFF, 16'sh7FFF, 16'sh7FFF);
        set_size(4'd15);
        send_item(CmdRdSample, 10'd1023, '0, '0, '0);
        send_item(CmdFwd, 10'd0, '0, '0, '0);
        send_item(CmdInv, 10'd0, '0, '0, '0);
        send_item(CmdRdSample, 10'd511, '0, '0, '0);
    endtask

    // Random phases at assorted sizes, mostly small; runs are rarer than loads.
    task automatic test_random_phases();
        logic [2:0]  cmd;
        logic [9:0]  idx;
        int unsigned pick;
        for (int ph = 0; ph < 8; ph++) begin
            pick = $urandom_range(99);
            if (pick < 60) set_size(4'($urandom_range(7, 4)));
            else if (pick < 80) set_size(4'($urandom_range(15)));
            else set_size(4'($urandom_range(10, 8)));
            gaps_on = (ph != 5);
            for (int k = 0; k < 32; k++) begin
                pick = $urandom_range(99);
                if (pick < 35) cmd = CmdWrSample;
                else if (pick < 50) cmd = CmdWrRot;
                else if (pick < 53) cmd = CmdFwd;
                else if (pick < 56) cmd = CmdInv;
                else if (pick < 94) cmd = CmdRdSample;
                else cmd = 3'($urandom_range(7, 5));
                if ($urandom_range(3) == 0) idx = 10'($urandom);
                else if (cmd == CmdWrRot) idx = 10'($urandom_range(RotEntries - 1));
                else idx = 10'($urandom_range((1 << vec_log2) - 1));
                // An in-range read of a never-written even sample moves to its odd neighbor.
                if (cmd == CmdRdSample && idx < (1 << vec_log2) && !sample_written[idx])
                    idx[0] = 1'b1;
                send_item(cmd, idx, t_sample'($urandom), t_coef'($urandom), t_coef'($urandom));
            end
        end
        gaps_on = 1'b1;
    endtask

    // Main sequence.
    initial begin
        error_count = 0;
        gaps_on = 1'b1;
        vec_log2 = 4;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_data <= '0;
        i_command <= '0;
        i_index <= '0;
        i_sample_value <= '0;
        i_sine_value <= '0;
        i_cosine_value <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fill_storage();
        test_directed();
        test_random_phases();
        start <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending_replies.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #30000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
